// ===== hdl/fifo_cache_replacement_tracker_macros.svh =====
// Assertion macros for the FIFO cache replacement tracker.
`ifndef FIFO_CACHE_REPLACEMENT_TRACKER_MACROS_SVH
`define FIFO_CACHE_REPLACEMENT_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define FCRT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCRT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCRT_ASSERT(name, prop, msg)
`define FCRT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== hdl/fcrt_pkg.sv =====
// Types, constants and helpers for the FIFO cache replacement tracker.
`default_nettype none

package fcrt_pkg;

  localparam int ADDR_W    = 16;
  localparam int CAP_W     = 9;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 48;
  localparam int SQ_W      = 64;
  localparam int RING_W    = ADDR_W + CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd16;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_EVICT = 6'b001000,
    S_ACC   = 6'b010000,
    S_OUT   = 6'b100000
  } fcrt_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fifo_cache_replacement_tracker.sv =====
// FIFO cache replacement tracker: presence map, insertion ring and running statistics.
`default_nettype none
`include "fifo_cache_replacement_tracker_macros.svh"

// Fully associative FIFO cache tracker. One transfer in carries a block address; one
// transfer out reports hit, any eviction with its age, and saturating statistics. An access
// on a hit or a fill without eviction has a presence-map/ring read, an update and a result
// load; an eviction adds an evict and an accumulate state, set by the single write port of
// the presence map (set new bit, clear evicted bit) and the registered squarer for the age
// square sum. After reset and after every capacity write the presence map is swept clear,
// one entry per cycle, with in_stall high; capacity writes are taken at any time.
module fifo_cache_replacement_tracker
  import fcrt_pkg::*;
#(
  parameter int CAP_MAX = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ADDR_W-1:0] in_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_hit,
  output logic                   out_evicted,
  output logic [ADDR_W-1:0]      out_evicted_address,
  output logic [CNT_W-1:0]       out_eviction_age,
  output logic [CNT_W-1:0]       out_access_count,
  output logic [CNT_W-1:0]       out_miss_count,
  output logic [CNT_W-1:0]       out_cold_fill_mark,
  output logic [CNT_W-1:0]       out_eviction_count,
  output logic [SUM_W-1:0]       out_age_sum,
  output logic [SQ_W-1:0]        out_age_square_sum
);

  localparam int RING_DEPTH = CAP_MAX + 1;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int MAP_DEPTH  = 2 ** ADDR_W;

  function automatic logic [PTR_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [PTR_W-1:0] r;
    r = PTR_W'(v);
    if (v == '0) begin
      r = PTR_W'(1);
    end else if (32'(v) > CAP_MAX) begin
      r = PTR_W'(CAP_MAX);
    end
    return r;
  endfunction

  fcrt_state_t state_r, state_nxt;

  logic [PTR_W-1:0]  cap_r;
  logic [PTR_W-1:0]  ins_ptr_r;
  logic [PTR_W-1:0]  old_ptr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] addr_r;

  logic [CNT_W-1:0]  acc_r;
  logic [CNT_W-1:0]  miss_r;
  logic [CNT_W-1:0]  cold_r;
  logic [CNT_W-1:0]  evc_r;
  logic [SUM_W-1:0]  age_tot_r;
  logic [SQ_W-1:0]   sq_tot_r;

  logic              hit_r;
  logic              ev_r;
  logic [ADDR_W-1:0] ev_addr_r;
  logic [CNT_W-1:0]  age_r;
  logic [SQ_W-1:0]   sq_r;

  logic              map_mem [MAP_DEPTH];
  logic              map_q_r;
  logic [RING_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_W-1:0] ring_q_r;

  logic              map_we;
  logic [ADDR_W-1:0] map_wa;
  logic              map_wd;
  logic              ring_we;

  logic              in_acc;
  logic              out_valid_r;
  logic              out_load;
  logic [CNT_W-1:0]  acc_inc;
  logic [PTR_W-1:0]  ins_next;
  logic [PTR_W-1:0]  old_next;
  logic              ring_full;
  logic [SUM_W:0]    age_sum_w;
  logic [SQ_W:0]     sq_sum_w;

  logic              o_hit_r;
  logic              o_ev_r;
  logic [ADDR_W-1:0] o_ev_addr_r;
  logic [CNT_W-1:0]  o_age_r;
  logic [CNT_W-1:0]  o_acc_r;
  logic [CNT_W-1:0]  o_miss_r;
  logic [CNT_W-1:0]  o_cold_r;
  logic [CNT_W-1:0]  o_evc_r;
  logic [SUM_W-1:0]  o_age_tot_r;
  logic [SQ_W-1:0]   o_sq_tot_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign acc_inc   = sat_inc(acc_r);
  assign ins_next  = (ins_ptr_r >= cap_r) ? '0 : ins_ptr_r + 1'b1;
  assign old_next  = (old_ptr_r >= cap_r) ? '0 : old_ptr_r + 1'b1;
  assign ring_full = (ins_next == old_ptr_r);
  assign ring_we   = (state_r == S_LOOK) && !map_q_r;

  assign age_sum_w = {1'b0, age_tot_r} + {{(SUM_W - CNT_W + 1){1'b0}}, age_r};
  assign sq_sum_w  = {1'b0, sq_tot_r} + {1'b0, sq_r};

  always_comb begin
    map_we = 1'b0;
    map_wa = clr_cnt_r;
    map_wd = 1'b0;
    unique case (state_r)
      S_CLEAR: map_we = 1'b1;
      S_LOOK: begin
        map_we = !map_q_r;
        map_wa = addr_r;
        map_wd = 1'b1;
      end
      S_EVICT: begin
        map_we = 1'b1;
        map_wa = ev_addr_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = (!map_q_r && ring_full) ? S_EVICT : S_OUT;
      S_EVICT: state_nxt = S_ACC;
      S_ACC:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // presence map: one write port, registered read
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (in_acc) map_q_r <= map_mem[in_address];
  end

  // insertion ring: {address, entry access number}
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ins_ptr_r] <= {addr_r, acc_inc};
    if (in_acc) ring_q_r <= ring_mem[old_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cap_r     <= clamp_cap(CAP_RESET);
      ins_ptr_r <= '0;
      old_ptr_r <= '0;
      clr_cnt_r <= '0;
      acc_r     <= '0;
      miss_r    <= '0;
      cold_r    <= '0;
      evc_r     <= '0;
      age_tot_r <= '0;
      sq_tot_r  <= '0;
    end else if (cfg_wr_en) begin
      state_r   <= S_CLEAR;
      cap_r     <= clamp_cap(cfg_wr_data);
      ins_ptr_r <= '0;
      old_ptr_r <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_LOOK) begin
        acc_r <= acc_inc;
        if (!map_q_r) begin
          miss_r    <= sat_inc(miss_r);
          ins_ptr_r <= ins_next;
          if (ring_full) begin
            evc_r     <= sat_inc(evc_r);
            old_ptr_r <= old_next;
          end else begin
            cold_r <= acc_inc;
          end
        end
      end
      if (state_r == S_EVICT) age_tot_r <= age_sum_w[SUM_W] ? '1 : age_sum_w[SUM_W-1:0];
      if (state_r == S_ACC)   sq_tot_r  <= sq_sum_w[SQ_W] ? '1 : sq_sum_w[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) addr_r <= in_address;
    if (state_r == S_LOOK) begin
      hit_r     <= map_q_r;
      ev_r      <= !map_q_r && ring_full;
      ev_addr_r <= ring_q_r[RING_W-1 -: ADDR_W];
      age_r     <= acc_inc - ring_q_r[CNT_W-1:0];
    end
    if (state_r == S_EVICT) sq_r <= {{(SQ_W - CNT_W){1'b0}}, age_r} *
                                    {{(SQ_W - CNT_W){1'b0}}, age_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_hit_r     <= hit_r;
      o_ev_r      <= ev_r;
      o_ev_addr_r <= ev_r ? ev_addr_r : '0;
      o_age_r     <= ev_r ? age_r : '0;
      o_acc_r     <= acc_r;
      o_miss_r    <= miss_r;
      o_cold_r    <= cold_r;
      o_evc_r     <= evc_r;
      o_age_tot_r <= age_tot_r;
      o_sq_tot_r  <= sq_tot_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = o_hit_r;
  assign out_evicted         = o_ev_r;
  assign out_evicted_address = o_ev_addr_r;
  assign out_eviction_age    = o_age_r;
  assign out_access_count    = o_acc_r;
  assign out_miss_count      = o_miss_r;
  assign out_cold_fill_mark  = o_cold_r;
  assign out_eviction_count  = o_evc_r;
  assign out_age_sum         = o_age_tot_r;
  assign out_age_square_sum  = o_sq_tot_r;

  `FCRT_ASSERT(a_accept_starts_lookup,
    in_valid && !in_stall && !cfg_wr_en |=> state_r == S_LOOK,
    "accepted transfer did not start a lookup")
  `FCRT_ASSERT(a_evict_only_on_miss,
    out_valid && out_evicted |-> !out_hit,
    "eviction reported on a hit")
  `FCRT_ASSERT(a_ptr_in_ring,
    ins_ptr_r <= cap_r && old_ptr_r <= cap_r,
    "ring pointer beyond capacity")
  `FCRT_ASSERT(a_count_order,
    evc_r <= miss_r && miss_r <= acc_r,
    "statistics counters out of order")

endmodule

`default_nettype wire
